>>> sv/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared widths, codes and types for the go-back-N sender window control.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Field widths and window limit.
  localparam int SEQ_BITS   = 16;
  localparam int TIMER_BITS = 24;
  localparam int WIN_BITS   = 6;
  localparam int WINDOW_MAX = 32;

  // Reset values of the configuration registers.
  localparam int TOTAL_RESET   = 0;
  localparam int WINDOW_RESET  = 4;
  localparam int TIMEOUT_RESET = 1000;

  // Stream widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = ((SEQ_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * SEQ_BITS + 7) / 8) * 8;
  localparam int CMD_BITS    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W0 = (SEQ_BITS > TIMER_BITS) ? SEQ_BITS : TIMER_BITS;
  localparam int CFG_DATA_W  = (CFG_DATA_W0 > WIN_BITS) ? CFG_DATA_W0 : WIN_BITS;

  // Event kinds carried in in_tuser.
  typedef enum logic [CMD_BITS-1:0] {
    CMD_START = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL   = 2'd0,
    REG_WINDOW  = 2'd1,
    REG_TIMEOUT = 2'd2
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_EMIT
  } state_t;

  // Request to the shared window compare unit.
  typedef struct packed {
    logic [SEQ_BITS-1:0] next_seq;
    logic                incr;
    logic [SEQ_BITS-1:0] base_seq;
    logic [WIN_BITS-1:0] win;
    logic [SEQ_BITS-1:0] limit;
  } cmp_req_t;

endpackage

>>> sv/gbn_cmp_unit.sv
// ----------------------------------------------------------------------------
// gbn_cmp_unit
// Shared window test: is a candidate sequence inside base plus window and
// below the packet total. Its result is used in the check and send steps.
// ----------------------------------------------------------------------------
module gbn_cmp_unit (
  input  gbn_pkg::cmp_req_t req,
  output logic              ok
);
  import gbn_pkg::*;

  logic [SEQ_BITS:0] cand;
  logic [SEQ_BITS:0] bound;

  // Candidate is next_seq or the one after it; no overflow in SEQ_BITS+1.
  always_comb begin
    cand  = {1'b0, req.next_seq} + (SEQ_BITS+1)'(req.incr);
    bound = {1'b0, req.base_seq} + (SEQ_BITS+1)'(req.win);
    ok    = (cand < bound) && (cand < {1'b0, req.limit});
  end

endmodule

>>> sv/go_back_n_sender_core.sv
// An event is captured when accepted and decoded in the exec state; the window is then
// checked in the check state, and each packet is loaded into the output register in the
// emit state, where a full register that out_tready does not drain holds the sequencer.
// The input is open only in the idle state, so a new event waits until the last one is
// done; one shared window compare unit serves the check step and each send step.
// Reset (rst_n low, synchronous) clears base, next and timer; total 0, window 4, timeout 1000.
// ----------------------------------------------------------------------------
// go_back_n_sender_core
// Go-back-N sender window control: start, ack and tick events drive a burst
// of sequence numbers to transmit, with a retransmit timer counted down by tick events.
// ----------------------------------------------------------------------------
module go_back_n_sender_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input events.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [gbn_pkg::IN_TDATA_W-1:0]      in_tdata,   // ack_seq
  input  logic [gbn_pkg::CMD_BITS-1:0]        in_tuser,   // cmd
  // Packets to send.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [gbn_pkg::OUT_TDATA_W-1:0]     out_tdata,  // send_seq, window_base
  output logic                                out_tlast,  // last_of_burst
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gbn_pkg::*;

  // Configuration registers.
  logic [SEQ_BITS-1:0]   total_r;
  logic [WIN_BITS-1:0]   window_r;
  logic [TIMER_BITS-1:0] timeout_r;

  // Window and timer state.
  state_t                state_r, state_nxt;
  logic [SEQ_BITS-1:0]   base_r, base_nxt;
  logic [SEQ_BITS-1:0]   next_r, next_nxt;
  logic                  tmr_run_r, tmr_run_nxt;
  logic [TIMER_BITS-1:0] tmr_rem_r, tmr_rem_nxt;

  // Captured event.
  cmd_t                  cmd_r;
  logic [SEQ_BITS-1:0]   ack_r;

  // Output holding register.
  logic                  out_valid_r, out_valid_nxt;
  logic [SEQ_BITS-1:0]   out_seq_r, out_seq_nxt;
  logic [SEQ_BITS-1:0]   out_base_r, out_base_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_load;

  // Shared compare unit.
  cmp_req_t              cmp_req;
  logic                  cmp_ok;

  // Event decode helpers.
  logic [WIN_BITS-1:0]   win_eff;
  logic [TIMER_BITS-1:0] arm_val;
  logic                  ack_take;
  logic [SEQ_BITS-1:0]   ack_base;
  logic [SEQ_BITS-1:0]   ack_next;
  logic                  in_fire;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= SEQ_BITS'(TOTAL_RESET);
      window_r  <= WIN_BITS'(WINDOW_RESET);
      timeout_r <= TIMER_BITS'(TIMEOUT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_TOTAL:   total_r   <= cfg_data[SEQ_BITS-1:0];
        REG_WINDOW:  window_r  <= cfg_data[WIN_BITS-1:0];
        REG_TIMEOUT: timeout_r <= cfg_data[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Window clamp and timer reload value.
  always_comb begin
    if ({1'b0, window_r} > (WIN_BITS+1)'(WINDOW_MAX)) begin
      win_eff = WIN_BITS'(WINDOW_MAX);
    end else begin
      win_eff = window_r;
    end
    arm_val = (timeout_r == '0) ? TIMER_BITS'(1) : timeout_r;
  end

  // Ack decode: an all-ones or stale ack leaves base alone.
  always_comb begin
    ack_take = (ack_r != '1) && (ack_r >= base_r);
    ack_base = ack_take ? SEQ_BITS'(ack_r + SEQ_BITS'(1)) : base_r;
    ack_next = (next_r < ack_base) ? ack_base : next_r;
  end

  // The compare unit tests next_seq in the check step and the following
  // sequence in each send step.
  always_comb begin
    cmp_req.next_seq = next_r;
    cmp_req.incr     = (state_r == ST_EMIT);
    cmp_req.base_seq = base_r;
    cmp_req.win      = win_eff;
    cmp_req.limit    = total_r;
  end

  gbn_cmp_unit u_cmp (
    .req (cmp_req),
    .ok  (cmp_ok)
  );

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    next_nxt     = next_r;
    tmr_run_nxt  = tmr_run_r;
    tmr_rem_nxt  = tmr_rem_r;
    out_load     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_seq_nxt  = out_seq_r;
    out_base_nxt = out_base_r;
    out_last_nxt = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (cmd_r)
          CMD_START: begin
            state_nxt = ST_CHECK;
            if (!tmr_run_r) begin
              tmr_run_nxt = 1'b1;
              tmr_rem_nxt = arm_val;
            end
          end
          CMD_ACK: begin
            base_nxt = ack_base;
            next_nxt = ack_next;
            if (ack_take) begin
              if (ack_base == ack_next) begin
                tmr_run_nxt = 1'b0;
                tmr_rem_nxt = '0;
              end else begin
                tmr_run_nxt = 1'b1;
                tmr_rem_nxt = arm_val;
              end
            end
            if (ack_base < total_r) begin
              state_nxt = ST_CHECK;
              // Sending arms a stopped timer.
              if (!tmr_run_nxt) begin
                tmr_run_nxt = 1'b1;
                tmr_rem_nxt = arm_val;
              end
            end
          end
          CMD_TICK: begin
            if (tmr_run_r) begin
              if (tmr_rem_r > TIMER_BITS'(1)) begin
                tmr_rem_nxt = tmr_rem_r - TIMER_BITS'(1);
              end else begin
                // Timeout: go back to base, re-arm the timer and resend.
                next_nxt    = base_r;
                tmr_run_nxt = 1'b1;
                tmr_rem_nxt = arm_val;
                state_nxt   = ST_CHECK;
              end
            end
          end
          default: ;
        endcase
      end

      ST_CHECK: begin
        state_nxt = cmp_ok ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        // Load one packet when the holding register is free or draining.
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_seq_nxt   = next_r;
          out_base_nxt  = base_r;
          out_last_nxt  = !cmp_ok;
          next_nxt      = SEQ_BITS'(next_r + SEQ_BITS'(1));
          if (!cmp_ok) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      tmr_run_r   <= 1'b0;
      tmr_rem_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      tmr_run_r   <= tmr_run_nxt;
      tmr_rem_r   <= tmr_rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Event capture and output payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd_t'(in_tuser);
      ack_r <= in_tdata[SEQ_BITS-1:0];
    end
    if (out_load) begin
      out_seq_r  <= out_seq_nxt;
      out_base_r <= out_base_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_base_r, out_seq_r});

endmodule

>>> sv/gbn_checker.sv
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks on the go-back-N sender: burst framing and handshakes.
// ----------------------------------------------------------------------------
module gbn_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gbn_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import gbn_pkg::*;

  // An accepted event closes the input in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready stayed high after an accepted event");

  // While a burst is unfinished no new event is taken.
  a_busy_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open while a burst is unfinished");

  // A burst continues without gaps once its consumer keeps up.
  a_burst_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("burst broke off before its last transaction");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind go_back_n_sender_core gbn_checker u_gbn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
